[sv/arp_pkg.sv]
// Package with the sizes, codes and word types of the ARP reply table.
package arp_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  localparam int unsigned IpW    = 32;
  localparam int unsigned MacW   = 48;
  localparam int unsigned EntryW = IpW + MacW;

  localparam logic        CmdAdd     = 1'b0;
  localparam logic [15:0] OpcRequest = 16'd1;

  typedef enum logic [2:0] {
    ST_NONE = 3'd0,
    ST_HIT  = 3'd1,
    ST_MISS = 3'd2,
    ST_ADD  = 3'd3,
    ST_FULL = 3'd4
  } arp_status_e;

  typedef struct packed {
    logic             command;
    logic [IpW-1:0]   entry_ip;
    logic [MacW-1:0]  entry_mac;
    logic [15:0]      arp_opcode;
    logic [IpW-1:0]   sender_ip;
    logic [IpW-1:0]   target_ip;
  } arp_item_t;

  typedef struct packed {
    arp_status_e      status;
    logic [MacW-1:0]  reply_sender_mac;
    logic [IpW-1:0]   reply_sender_ip;
    logic [IpW-1:0]   reply_target_ip;
  } arp_result_t;

endpackage

[sv/arp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module arp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[sv/arp_reply_table.sv]
// Top level of the ARP reply table: entry store, lookup sequencer and result register.
//
// The block holds up to TableDepth IPv4-to-MAC entries in one RAM, in the
// order they were added. A word is taken when start is high and busy is low.
// An add word writes the next free entry and reports "added", or reports
// "table full" once all entries are in use; its result appears on the
// cycle after it was taken and busy never rises. A packet word whose opcode
// is not request gives a "no action" result on the next cycle. A request
// word scans the stored entries from the oldest, one RAM read per cycle,
// and answers with the MAC of the first entry whose IP equals the target
// IP, or with a miss and a zero MAC. Its result is registered once the
// entry that hit (the last stored entry on a miss) has come back from the
// registered RAM read port and been compared; with an empty table the
// miss comes on the next cycle. Every result is shown for exactly one
// cycle with result_valid_o high and must be taken then, since the
// receiver cannot stall the block. There is no clearing pass after
// reset: the entry count alone marks which entries hold data.
module arp_reply_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  arp_pkg::arp_item_t   item_i,
  output logic                 result_valid_o,
  output arp_pkg::arp_result_t result_o
);
  import arp_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic        pend_q, pend_d;
  logic [IpW-1:0] want_ip_q, want_ip_d;
  logic [IpW-1:0] peer_ip_q, peer_ip_d;
  arp_result_t result_q, result_d;
  logic        valid_q, valid_d;

  logic              ram_we;
  logic              ram_re;
  logic [EntryW-1:0] ram_rdata;
  logic [IpW-1:0]    rd_ip;
  logic [MacW-1:0]   rd_mac;
  logic              issue;

  // Entries are stored as {ip, mac}; a new entry always goes to the slot
  // at the current count.
  arp_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i ({item_i.entry_ip, item_i.entry_mac}),
    .re_i    (ram_re),
    .raddr_i (ptr_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_ip  = ram_rdata[EntryW-1:MacW];
  assign rd_mac = ram_rdata[MacW-1:0];

  // A read is issued while there are stored entries left to look at.
  assign issue = (state_q == S_SCAN) && (ptr_q < count_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    pend_d    = 1'b0;
    want_ip_d = want_ip_q;
    peer_ip_d = peer_ip_q;
    result_d  = result_q;
    valid_d   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          result_d = '0;
          if (item_i.command == CmdAdd) begin
            valid_d = 1'b1;
            if (count_q < CntW'(TableDepth)) begin
              ram_we          = 1'b1;
              count_d         = count_q + CntW'(1);
              result_d.status = ST_ADD;
            end else begin
              result_d.status = ST_FULL;
            end
          end else if (item_i.arp_opcode != OpcRequest) begin
            valid_d         = 1'b1;
            result_d.status = ST_NONE;
          end else if (count_q == '0) begin
            // Nothing stored: the answer is a miss right away.
            valid_d                  = 1'b1;
            result_d.status          = ST_MISS;
            result_d.reply_sender_ip = item_i.target_ip;
            result_d.reply_target_ip = item_i.sender_ip;
          end else begin
            state_d   = S_SCAN;
            ptr_d     = '0;
            want_ip_d = item_i.target_ip;
            peer_ip_d = item_i.sender_ip;
          end
        end
      end
      S_SCAN: begin
        // Reads are pipelined: pend_q marks that ram_rdata holds the entry
        // read on the previous cycle.
        ram_re = issue;
        pend_d = issue;
        if (issue) begin
          ptr_d = ptr_q + CntW'(1);
        end
        if (pend_q && (rd_ip == want_ip_q)) begin
          state_d                   = S_IDLE;
          pend_d                    = 1'b0;
          valid_d                   = 1'b1;
          result_d.status           = ST_HIT;
          result_d.reply_sender_mac = rd_mac;
          result_d.reply_sender_ip  = want_ip_q;
          result_d.reply_target_ip  = peer_ip_q;
        end else if (pend_q && !issue) begin
          state_d                   = S_IDLE;
          valid_d                   = 1'b1;
          result_d.status           = ST_MISS;
          result_d.reply_sender_mac = '0;
          result_d.reply_sender_ip  = want_ip_q;
          result_d.reply_target_ip  = peer_ip_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    want_ip_q <= want_ip_d;
    peer_ip_q <= peer_ip_d;
    result_q  <= result_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign result_o       = result_q;

`ifndef NO_ASSERTIONS
  // The entry count never runs past the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth))
    else $error("entry count exceeds table depth");

  // Leaving the scan always delivers exactly the lookup's result.
  a_scan_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && state_d == S_IDLE) |=> result_valid_o)
    else $error("scan ended without a result");

  // An added result goes with a count that grew by one.
  a_add_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status == ST_ADD) |->
      count_q == $past(count_q) + CntW'(1))
    else $error("add result without a new entry");

  // A full report only comes when every entry is in use.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status == ST_FULL) |->
      count_q == CntW'(TableDepth))
    else $error("table full reported with free entries");

  // No result is shown while a scan is still running.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !result_valid_o)
    else $error("result shown during scan");
`endif

endmodule
